[hdl/assert_macros.svh]
// Assertion macros shared by the RTL, empty when synthesized.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/deq_pkg.sv]
// Shared constants, types and ring-index helper of the double-ended queue.
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  // Action codes of an input item
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_REAR   = 3'd3;
  localparam logic [2:0] ACT_DUMP       = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Datapath operations
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE       = 3'd0;
  localparam op_t OP_FLAG       = 3'd1;
  localparam op_t OP_PUSH_FRONT = 3'd2;
  localparam op_t OP_PUSH_REAR  = 3'd3;
  localparam op_t OP_POP_FRONT  = 3'd4;
  localparam op_t OP_POP_REAR   = 3'd5;
  localparam op_t OP_DUMP_START = 3'd6;
  localparam op_t OP_DUMP_NEXT  = 3'd7;

  typedef struct packed {
    op_t        op;          // operation applied at this edge
    logic [1:0] status;      // status code for OP_FLAG
    logic       take_rdata;  // load result register from the store read port
    logic       dumping;     // a dump is in progress
  } cmd_t;

  typedef struct packed {
    logic empty;       // no entries stored
    logic full;        // DEPTH entries stored
    logic last_entry;  // dump offset points at the rear entry
  } sts_t;

  // Ring position head + offset, modulo DEPTH (offset never exceeds DEPTH).
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[hdl/deq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/deq_ctrl.sv]
// Controller state machine: handshakes and sequencing of queue operations.
module deq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [2:0]    in_action,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  deq_pkg::sts_t sts,
  output deq_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic       dump_r, dump_nxt;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);

  always_comb begin
    st_nxt         = st_r;
    dump_nxt       = dump_r;
    cmd.op         = deq_pkg::OP_NONE;
    cmd.status     = deq_pkg::ST_OK;
    cmd.take_rdata = 1'b0;
    cmd.dumping    = dump_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR: begin
              if (sts.full) begin
                cmd.op     = deq_pkg::OP_FLAG;
                cmd.status = deq_pkg::ST_OVERFLOW;
              end else if (in_action == deq_pkg::ACT_PUSH_FRONT) begin
                cmd.op = deq_pkg::OP_PUSH_FRONT;
              end else begin
                cmd.op = deq_pkg::OP_PUSH_REAR;
              end
              st_nxt = S_OUT;
            end
            deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_REAR: begin
              if (sts.empty) begin
                cmd.op     = deq_pkg::OP_FLAG;
                cmd.status = deq_pkg::ST_UNDERFLOW;
                st_nxt     = S_OUT;
              end else begin
                cmd.op = (in_action == deq_pkg::ACT_POP_FRONT) ?
                         deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_REAR;
                st_nxt = S_READ;
              end
            end
            deq_pkg::ACT_DUMP: begin
              if (sts.empty) begin
                cmd.op     = deq_pkg::OP_FLAG;
                cmd.status = deq_pkg::ST_EMPTY;
                st_nxt     = S_OUT;
              end else begin
                cmd.op   = deq_pkg::OP_DUMP_START;
                dump_nxt = 1'b1;
                st_nxt   = S_READ;
              end
            end
            default: begin
              // unknown action: drop the item without a result
            end
          endcase
        end
      end
      S_READ: begin
        cmd.take_rdata = 1'b1;
        st_nxt         = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (dump_r && !sts.last_entry) begin
            cmd.op = deq_pkg::OP_DUMP_NEXT;
            st_nxt = S_READ;
          end else begin
            dump_nxt = 1'b0;
            st_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        st_nxt   = S_IDLE;
        dump_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      dump_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      dump_r <= dump_nxt;
    end
  end

endmodule

[hdl/deq_dpath.sv]
// Datapath: ring store, head, count, dump offset and result register.
module deq_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [deq_pkg::DATA_W-1:0]  in_value,
  input  deq_pkg::cmd_t               cmd,
  output deq_pkg::sts_t               sts,
  output logic [1:0]                  out_status,
  output logic [deq_pkg::DATA_W-1:0]  out_element,
  output logic                        out_last
);

  logic [deq_pkg::IDX_W-1:0]  head_r, head_nxt;
  logic [deq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [deq_pkg::IDX_W-1:0]  off_r, off_nxt;
  logic [deq_pkg::IDX_W-1:0]  head_dec;
  logic [deq_pkg::CNT_W-1:0]  off_inc;
  logic [deq_pkg::CNT_W-1:0]  rd_off;
  logic [deq_pkg::IDX_W-1:0]  raddr, waddr;
  logic                       we;
  logic [deq_pkg::DATA_W-1:0] rdata;
  logic [1:0]                 status_r, status_nxt;
  logic [deq_pkg::DATA_W-1:0] element_r, element_nxt;
  logic                       last_r, last_nxt;

  assign head_dec = (head_r == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1) : head_r - 1'b1;
  assign off_inc  = deq_pkg::CNT_W'(off_r) + deq_pkg::CNT_W'(1);

  assign sts.empty      = (count_r == '0);
  assign sts.full       = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign sts.last_entry = (off_inc == count_r);

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    off_nxt     = off_r;
    we          = 1'b0;
    waddr       = head_dec;
    rd_off      = '0;
    status_nxt  = status_r;
    element_nxt = element_r;
    last_nxt    = last_r;
    case (cmd.op)
      deq_pkg::OP_FLAG: begin
        status_nxt  = cmd.status;
        element_nxt = '0;
        last_nxt    = 1'b1;
      end
      deq_pkg::OP_PUSH_FRONT: begin
        we          = 1'b1;
        waddr       = head_dec;
        head_nxt    = head_dec;
        count_nxt   = count_r + 1'b1;
        status_nxt  = deq_pkg::ST_OK;
        element_nxt = '0;
        last_nxt    = 1'b1;
      end
      deq_pkg::OP_PUSH_REAR: begin
        we          = 1'b1;
        waddr       = deq_pkg::slot(head_r, count_r);
        count_nxt   = count_r + 1'b1;
        status_nxt  = deq_pkg::ST_OK;
        element_nxt = '0;
        last_nxt    = 1'b1;
      end
      deq_pkg::OP_POP_FRONT: begin
        rd_off    = '0;
        head_nxt  = deq_pkg::slot(head_r, deq_pkg::CNT_W'(1));
        count_nxt = count_r - 1'b1;
      end
      deq_pkg::OP_POP_REAR: begin
        rd_off    = count_r - 1'b1;
        count_nxt = count_r - 1'b1;
      end
      deq_pkg::OP_DUMP_START: begin
        rd_off  = '0;
        off_nxt = '0;
      end
      deq_pkg::OP_DUMP_NEXT: begin
        rd_off  = off_inc;
        off_nxt = off_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (cmd.take_rdata) begin
      status_nxt  = deq_pkg::ST_OK;
      element_nxt = rdata;
      last_nxt    = !cmd.dumping || sts.last_entry;
    end
  end

  assign raddr = deq_pkg::slot(head_r, rd_off);

  deq_ram #(
    .WIDTH(deq_pkg::DATA_W),
    .DEPTH(deq_pkg::DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(in_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      off_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      off_r   <= off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    element_r <= element_nxt;
    last_r    <= last_nxt;
  end

  assign out_status  = status_r;
  assign out_element = element_r;
  assign out_last    = last_r;

endmodule

[hdl/double_ended_queue.sv]
// Top level of the double-ended queue: controller, datapath and checks.
// Double-ended queue of signed 32-bit values in a ring store of deq_pkg::DEPTH
// entries (a single-write, registered-read RAM), tracked by a head index and
// an entry count. Each input item carries an action: push front, push rear,
// pop front, pop rear or dump. A push or pop gives one result with last set;
// a push into a full queue is dropped with overflow status, a pop from an
// empty queue returns underflow. A dump gives every entry from front to rear
// and sets last on the rear one; a dump of an empty queue gives one result
// with empty status. Action codes 5 to 7 are dropped without a result. One
// item is handled at a time: in_ready is high only while the block is idle.
// A push or a flagged item is accepted, then its result is held until taken;
// a pop adds a registered RAM read between acceptance and result; a dump
// costs one RAM read plus a result handshake for each entry. A stall on
// out_ready holds the result. After reset the queue is empty and the first
// item may be taken at once.
`include "assert_macros.svh"

module double_ended_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_element,
  output logic               out_last
);

  deq_pkg::cmd_t cmd;
  deq_pkg::sts_t sts;
  logic [deq_pkg::DATA_W-1:0] element;

  // Sequence the handshakes and issue one datapath operation per edge
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the queue state and the result register
  deq_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_status),
    .out_element(element),
    .out_last   (out_last)
  );

  assign out_element = $signed(element);

  // Never take an item while a result is pending
  `ASSERT_IMPLIES(a_one_at_a_time, clk, rst_n, out_valid, !in_ready)

  // A RAM read is always followed by a result shown on the next edge
  `ASSERT_NEXT(a_read_shows, clk, rst_n, cmd.take_rdata, out_valid)

  // A successful push yields an ok result with last set and zero element
  `ASSERT_NEXT(a_push_ok, clk, rst_n,
    (cmd.op == deq_pkg::OP_PUSH_FRONT) || (cmd.op == deq_pkg::OP_PUSH_REAR),
    out_valid && (out_status == deq_pkg::ST_OK) && out_last && (out_element == '0))

  // Any non-ok result ends its item and carries no element
  `ASSERT_IMPLIES(a_flag_last, clk, rst_n,
    out_valid && (out_status != deq_pkg::ST_OK), out_last && (out_element == '0))

endmodule

[tb/sv/double_ended_queue_tb.sv]
// Self-checking testbench of the double-ended queue: directed table, then random traffic.
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int RANDOM_ITEMS = 145;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [7:0]         reps;
    logic               typed;   // expected result written in the row
    logic [1:0]         status;  // typed status; element 0, last 1
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_action;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic signed [31:0] out_element;
  logic               out_last;

  // Shadow copy of the ring store, front position and fill level
  logic signed [31:0] ring [DEPTH];
  logic [IDX_W-1:0]   front;
  logic [CNT_W-1:0]   fill;

  result_t   pending_results [$];
  stim_row_t directed_rows [$];
  int        mismatch_count;
  bit        calm;          // no idling on either side while set
  bit        hold_request;  // sender asks the receiver for one long hold-off

  double_ended_queue dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_element (out_element),
    .out_last    (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the shadow deque by one accepted item and, if keep is set, queue
  // the results that the block must return for it.
  function automatic void predict_queue_action(input logic [2:0] act,
                                               input logic signed [31:0] val,
                                               input bit keep);
    result_t r;
    int      k;
    r.status  = ST_OK;
    r.element = '0;
    r.last    = 1'b1;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (fill == CNT_W'(DEPTH)) begin
          // full: drop the value, flag overflow
          r.status = ST_OVERFLOW;
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            front = IDX_W'((int'(front) + DEPTH - 1) % DEPTH);
            ring[front] = val;
          end else begin
            ring[IDX_W'((int'(front) + int'(fill)) % DEPTH)] = val;
          end
          fill = fill + 1'b1;
        end
        if (keep) pending_results.push_back(r);
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (fill == '0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          if (act == ACT_POP_FRONT) begin
            r.element = ring[front];
            front = IDX_W'((int'(front) + 1) % DEPTH);
          end else begin
            r.element = ring[IDX_W'((int'(front) + int'(fill) - 1) % DEPTH)];
          end
          fill = fill - 1'b1;
        end
        if (keep) pending_results.push_back(r);
      end
      ACT_DUMP: begin
        if (fill == '0) begin
          r.status = ST_EMPTY;
          if (keep) pending_results.push_back(r);
        end else begin
          // walk front to rear, mark the rear entry as last
          for (k = 0; k < int'(fill); k++) begin
            r.element = ring[IDX_W'((int'(front) + k) % DEPTH)];
            r.last    = (k == int'(fill) - 1);
            if (keep) pending_results.push_back(r);
          end
        end
      end
      default: ; // unknown action: no result, state untouched
    endcase
  endfunction

  function automatic stim_row_t mk_row(input logic [2:0] act, input logic signed [31:0] val,
                                       input int reps, input bit typed,
                                       input logic [1:0] st);
    stim_row_t row;
    row.action = act;
    row.value  = val;
    row.reps   = 8'(reps);
    row.typed  = typed;
    row.status = st;
    return row;
  endfunction

  // Offer one item, hold it until accepted, then record what it must return.
  // Call at a rising edge; returns at the edge that accepted the item.
  task automatic drive_item(input logic [2:0] act, input logic signed [31:0] val,
                            input bit typed, input logic [1:0] st);
    int      gap;
    result_t want;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_queue_action(act, val, !typed);
    if (typed) begin
      want.status  = st;
      want.element = '0;
      want.last    = 1'b1;
      pending_results.push_back(want);
    end
  endtask

  // Draw a value, leaning toward the extremes now and then.
  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: take results with random stalls and compare each one with the
  // oldest expectation.
  initial begin
    int      stall;
    bit      hold_done;
    result_t want;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d element %0d last %0d",
                 $time, out_status, out_element, out_last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
          mismatch_count++;
        end
        if (out_element !== want.element) begin
          $display("%0t: element expected %0d got %0d", $time, want.element, out_element);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0d got %0d", $time, want.last, out_last);
          mismatch_count++;
        end
      end
      // hold off once for a long stretch so the block fills up and stalls
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if the traffic stops moving.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("double_ended_queue_tb NOT OK");
        $finish;
      end
    end
  end

  // Sender: reset, directed table, random traffic, drain.
  initial begin
    int              i;
    int              r;
    int              counted;
    int              push_pct;
    logic [2:0]      act;
    stim_row_t       row;

    mismatch_count = 0;
    calm           = 1'b0;
    hold_request   = 1'b0;
    front          = '0;
    fill           = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_action <= ACT_PUSH_FRONT;
    in_value  <= '0;

    // Empty queue first, then the value extremes at both ends, the unknown
    // codes, a full queue from both ends, and a drain back to empty.
    directed_rows.push_back(mk_row(ACT_POP_FRONT,  32'sd0,         1,  1, ST_UNDERFLOW));
    directed_rows.push_back(mk_row(ACT_POP_REAR,   32'sd77,        1,  1, ST_UNDERFLOW));
    directed_rows.push_back(mk_row(ACT_DUMP,       32'sd0,         1,  1, ST_EMPTY));
    directed_rows.push_back(mk_row(ACT_PUSH_FRONT, 32'sh7fff_ffff, 1,  1, ST_OK));
    directed_rows.push_back(mk_row(ACT_PUSH_REAR,  32'sh8000_0000, 1,  1, ST_OK));
    directed_rows.push_back(mk_row(ACT_PUSH_FRONT, -32'sd1,        1,  1, ST_OK));
    directed_rows.push_back(mk_row(ACT_PUSH_REAR,  32'sd0,         1,  1, ST_OK));
    directed_rows.push_back(mk_row(ACT_DUMP,       32'sd0,         1,  0, ST_OK));
    directed_rows.push_back(mk_row(ACT_POP_FRONT,  32'sd0,         1,  0, ST_OK));
    directed_rows.push_back(mk_row(ACT_POP_REAR,   32'sd0,         1,  0, ST_OK));
    directed_rows.push_back(mk_row(3'd5,           32'sd123,       1,  0, ST_OK));
    directed_rows.push_back(mk_row(3'd6,           -32'sd5,        1,  0, ST_OK));
    directed_rows.push_back(mk_row(3'd7,           32'sh8000_0000, 1,  0, ST_OK));
    directed_rows.push_back(mk_row(ACT_POP_FRONT,  -32'sd1,        1,  0, ST_OK));
    directed_rows.push_back(mk_row(ACT_PUSH_REAR,  32'sh5555_5555, 15, 1, ST_OK));
    directed_rows.push_back(mk_row(ACT_PUSH_FRONT, 32'sh1234,      1,  1, ST_OVERFLOW));
    directed_rows.push_back(mk_row(ACT_PUSH_REAR,  32'sh4321,      1,  1, ST_OVERFLOW));
    directed_rows.push_back(mk_row(ACT_DUMP,       32'sd0,         1,  0, ST_OK));
    directed_rows.push_back(mk_row(ACT_POP_REAR,   32'sd0,         1,  0, ST_OK));
    directed_rows.push_back(mk_row(ACT_POP_FRONT,  32'sd0,         1,  0, ST_OK));
    directed_rows.push_back(mk_row(ACT_PUSH_FRONT, 32'shaaaa_aaaa, 2,  1, ST_OK));
    directed_rows.push_back(mk_row(ACT_DUMP,       32'sd0,         1,  0, ST_OK));
    directed_rows.push_back(mk_row(ACT_POP_FRONT,  32'sd0,         16, 0, ST_OK));
    directed_rows.push_back(mk_row(ACT_POP_REAR,   32'sd0,         1,  1, ST_UNDERFLOW));
    directed_rows.push_back(mk_row(ACT_DUMP,       32'sd0,         1,  1, ST_EMPTY));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the table; a row with reps repeats its action with a stepped value.
    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      for (i = 0; i < int'(row.reps); i++) begin
        drive_item(row.action, row.value + i, row.typed, row.status);
      end
    end

    // Random traffic: the push share moves between phases so the queue swings
    // between full and empty. Unknown codes do not count toward the total.
    counted  = 0;
    push_pct = 75;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0 && counted > 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      hold_request = hold_request || (counted >= 40);
      calm = (counted >= 110 && counted < 135);

      r = $urandom_range(0, 99);
      if (r < 3) begin
        act = 3'($urandom_range(5, 7));
      end else if (r < 11) begin
        act = ACT_DUMP;
      end else if ($urandom_range(0, 99) < push_pct) begin
        act = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
      end else begin
        act = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
      end
      drive_item(act, draw_value(), 1'b0, ST_OK);
      if (act <= ACT_DUMP) counted++;

      // pause once until every expected result has come back
      if (counted == 100 && act <= ACT_DUMP) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch a while longer for stray results.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("double_ended_queue_tb OK");
    end else begin
      $display("double_ended_queue_tb NOT OK");
    end
    $finish;
  end

endmodule
